### rtl/core/clru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clru_pkg: shared types and constants of the word-read lookup cache
// Item layouts, register indexes, result kinds and fixed field widths.
// ----------------------------------------------------------------------------
package clru_pkg;

  localparam int unsigned Ways       = 4;
  localparam int unsigned WayW       = 2;
  localparam int unsigned BlockWords = 8;
  localparam int unsigned OffW       = 3;
  localparam int unsigned TagW       = 30;
  localparam int unsigned StampW     = 32;
  localparam int unsigned CntW       = 32;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMode      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd2;

  // Cache organization.
  localparam logic ModeDirect = 1'b0;
  localparam logic ModeAssoc  = 1'b1;

  localparam logic [3:0] SetBitsReset = 4'd4;

  // Input item functions.
  localparam logic FuncLookup = 1'b0;
  localparam logic FuncFill   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KindHit  = 2'd0;
  localparam logic [1:0] KindFill = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] fill_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DataW-1:0] read_word;
    logic [AddrW-1:0] fill_base;
    logic [3:0]       fill_count;
    logic             cold_miss;
    logic [CntW-1:0]  ref_total;
    logic [CntW-1:0]  hit_total;
    logic [CntW-1:0]  miss_total;
    logic [CntW-1:0]  cold_total;
    logic [CntW-1:0]  hot_total;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_wr_t;

  // Way choice for one set in four-way mode.
  typedef struct packed {
    logic            hit;
    logic [WayW-1:0] hit_way;
    logic            cold;
    logic [WayW-1:0] victim_way;
  } way_sel_t;

endpackage

### rtl/core/clru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clru_if: valid/ready channels of the lookup cache
// Input item channel, result item channel and configuration write channel.
// ----------------------------------------------------------------------------
interface clru_in_if;
  logic                valid;
  logic                ready;
  clru_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clru_out_if;
  logic                valid;
  logic                ready;
  clru_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clru_cfg_if;
  logic                valid;
  logic                ready;
  clru_pkg::cfg_wr_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/clru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clru_ram: generic simple dual-port RAM
// One write port, one read port with registered data; a read of the address
// being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module clru_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/clru_way_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clru_way_sel: hit and victim selection for one four-way set
// Lowest matching way hits; on a miss the highest invalid way is taken,
// else the way with the smallest stamp, lowest way on ties.
// ----------------------------------------------------------------------------
module clru_way_sel (
  input  logic [clru_pkg::Ways-1:0]                        valid_i,
  input  logic [clru_pkg::Ways-1:0]                        match_i,
  input  logic [clru_pkg::Ways-1:0][clru_pkg::StampW-1:0]  stamp_i,
  output clru_pkg::way_sel_t                               sel_o
);

  always_comb begin
    logic [clru_pkg::StampW-1:0] oldest;
    logic [clru_pkg::WayW-1:0]   old_way;
    logic [clru_pkg::WayW-1:0]   inval_way;
    sel_o     = '0;
    oldest    = stamp_i[0];
    old_way   = '0;
    inval_way = '0;
    for (int w = 0; w < clru_pkg::Ways; w++) begin
      if (!sel_o.hit && match_i[w]) begin
        sel_o.hit     = 1'b1;
        sel_o.hit_way = clru_pkg::WayW'(w);
      end
      if (!valid_i[w]) begin
        sel_o.cold = 1'b1;
        inval_way  = clru_pkg::WayW'(w);
      end
      if (stamp_i[w] < oldest) begin
        oldest  = stamp_i[w];
        old_way = clru_pkg::WayW'(w);
      end
    end
    sel_o.victim_way = sel_o.cold ? inval_way : old_way;
  end

endmodule

### rtl/core/cache_lookup_dm_sa_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_lookup_dm_sa_lru: word-read cache, direct mapped or four-way LRU
// Lookup items return a hit word or a block fill request; fill-word items
// load the pending block and the last one returns the requested word.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i takes register writes (mode, log2 words per block, set index bits)
//   and is always ready; write it only while no item is in flight.
//   in_i carries items: func selects a lookup of addr or one fill word.
//   out_o carries result items: a hit, a miss with its fill request, or the
//   end of a fill with the requested word, plus the running counters.
//   Lookups seen while a fill is pending, and fill words with no fill pending,
//   are dropped and give no result.
// Timing: one item per cycle while out_o takes its results. An item accepted
//   at one clock edge is decided in the next cycle, and its result is then
//   registered into the result register on out_o. The rate is set by the single
//   read and single write port of each tag, stamp and data RAM bank, one of each
//   per cycle; each way owns one bank, so a whole set is read in one access.
// Stalls: while out_o holds an untaken result, one more item can be accepted
//   into the decide stage; in_i.ready then drops until out_o is taken.
// Reset: all slots invalid, counters zero, mode direct, one word per block,
//   four set index bits. Valid and stamp-written bits are flip-flops, so there
//   is no clearing pass and items are taken right after reset.
// MaxSlots is a power of two from 8 to 4096.
// ----------------------------------------------------------------------------
module cache_lookup_dm_sa_lru #(
  parameter int unsigned MaxSlots = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clru_cfg_if.sink   cfg_i,
  clru_in_if.sink    in_i,
  clru_out_if.source out_o
);

  localparam int unsigned Ways      = clru_pkg::Ways;
  localparam int unsigned WayW      = clru_pkg::WayW;
  localparam int unsigned OffW      = clru_pkg::OffW;
  localparam int unsigned TagW      = clru_pkg::TagW;
  localparam int unsigned StampW    = clru_pkg::StampW;
  localparam int unsigned CntW      = clru_pkg::CntW;
  localparam int unsigned AddrW     = clru_pkg::AddrW;
  localparam int unsigned DataW     = clru_pkg::DataW;
  localparam int unsigned SlotW     = $clog2(MaxSlots);
  localparam int unsigned RowW      = SlotW - WayW;
  localparam int unsigned Rows      = MaxSlots / Ways;
  localparam int unsigned DataDepth = Rows * clru_pkg::BlockWords;
  localparam int unsigned DAddrW    = RowW + OffW;
  localparam logic [3:0]  KMaxDirect = 4'(SlotW);
  localparam logic [3:0]  KMaxAssoc  = 4'(RowW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       mode_q;
  logic [1:0] blk_bits_q;
  logic [3:0] set_bits_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= clru_pkg::ModeDirect;
      blk_bits_q <= '0;
      set_bits_q <= clru_pkg::SetBitsReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        clru_pkg::CfgMode:      mode_q     <= cfg_i.data.value[0];
        clru_pkg::CfgBlockBits: blk_bits_q <= cfg_i.data.value[1:0];
        clru_pkg::CfgSetBits:   set_bits_q <= cfg_i.data.value[3:0];
        default: ;
      endcase
    end
  end

  logic       assoc;
  logic [3:0] set_kmax;
  logic [3:0] set_bits;
  logic [3:0] words;

  assign assoc    = (mode_q == clru_pkg::ModeAssoc);
  assign set_kmax = assoc ? KMaxAssoc : KMaxDirect;
  // The set index is narrowed until sets times ways fit in the slots.
  assign set_bits = (set_bits_q > set_kmax) ? set_kmax : set_bits_q;
  assign words    = 4'd1 << blk_bits_q;

  // --------------------------------------------------------------------------
  // Address split at acceptance; it also addresses the RAM reads.
  // --------------------------------------------------------------------------
  logic              in_accept;
  logic [2:0]        blk_sh;
  logic [AddrW-1:0]  blk_addr;
  logic [AddrW-1:0]  tag_full;
  logic [SlotW-1:0]  set_idx;
  logic [OffW-1:0]   word_off;
  logic [AddrW-1:0]  blk_base;
  logic [RowW-1:0]   rd_row;
  logic [WayW-1:0]   rd_bank;

  assign in_accept = in_i.valid && in_i.ready;
  assign blk_sh    = 3'(blk_bits_q) + 3'd2;
  assign blk_addr  = in_i.data.addr >> blk_sh;
  assign tag_full  = blk_addr >> set_bits;
  assign set_idx   = blk_addr[SlotW-1:0] & ~({SlotW{1'b1}} << set_bits);
  assign word_off  = in_i.data.addr[2 +: OffW] & OffW'(words - 4'd1);
  assign blk_base  = in_i.data.addr & ~((32'd4 << blk_bits_q) - 32'd1);
  // Slot s lives in bank s mod 4, row s / 4. In direct-mapped mode the set is
  // the slot; in four-way mode the set is the row and all banks are searched.
  assign rd_row    = assoc ? set_idx[RowW-1:0] : set_idx[SlotW-1:WayW];
  assign rd_bank   = assoc ? '0 : set_idx[WayW-1:0];

  // --------------------------------------------------------------------------
  // Decide stage registers
  // --------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_func_q;
  logic [TagW-1:0]  s1_tag_q;
  logic [RowW-1:0]  s1_row_q;
  logic [WayW-1:0]  s1_bank_q;
  logic [OffW-1:0]  s1_off_q;
  logic [AddrW-1:0] s1_base_q;
  logic [DataW-1:0] s1_fill_word_q;
  logic             s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q      <= in_i.data.func;
      s1_tag_q       <= tag_full[TagW-1:0];
      s1_row_q       <= rd_row;
      s1_bank_q      <= rd_bank;
      s1_off_q       <= word_off;
      s1_base_q      <= blk_base;
      s1_fill_word_q <= in_i.data.fill_word;
    end
  end

  assign in_i.ready = !s1_valid_q || s1_fire;

  // --------------------------------------------------------------------------
  // Cache state
  // --------------------------------------------------------------------------
  logic [MaxSlots-1:0] slot_valid_q;
  logic [MaxSlots-1:0] stamp_set_q;
  logic [CntW-1:0]     ref_cnt_q, hit_cnt_q, miss_cnt_q, cold_cnt_q, hot_cnt_q;
  logic                fill_pending_q;
  logic [SlotW-1:0]    pending_slot_q;
  logic [OffW-1:0]     pending_off_q;
  logic [3:0]          fill_progress_q;
  logic [DataW-1:0]    req_word_q;

  logic [Ways-1:0][TagW-1:0]   tag_rd;
  logic [Ways-1:0][StampW-1:0] stamp_rd;
  logic [Ways-1:0][DataW-1:0]  data_rd;
  logic [Ways-1:0]             tag_we, stamp_we, data_we;
  logic [Ways-1:0]             way_valid, way_match;
  logic [Ways-1:0][StampW-1:0] way_stamp;
  logic [StampW-1:0]           stamp_wdata;
  logic [DAddrW-1:0]           data_waddr;
  logic [DAddrW-1:0]           data_raddr;

  assign stamp_wdata = ref_cnt_q + 32'd1;
  assign data_waddr  = {pending_slot_q[SlotW-1:WayW], fill_progress_q[OffW-1:0]};
  assign data_raddr  = {rd_row, word_off};

  // One bank per way for tags, stamps and block words.
  for (genvar w = 0; w < Ways; w++) begin : g_way
    clru_ram #(.Width(TagW), .Depth(Rows)) u_tag_ram (
      .clk_i   (clk_i),
      .we_i    (tag_we[w]),
      .waddr_i (s1_row_q),
      .wdata_i (s1_tag_q),
      .re_i    (in_accept),
      .raddr_i (rd_row),
      .rdata_o (tag_rd[w])
    );

    clru_ram #(.Width(StampW), .Depth(Rows)) u_stamp_ram (
      .clk_i   (clk_i),
      .we_i    (stamp_we[w]),
      .waddr_i (s1_row_q),
      .wdata_i (stamp_wdata),
      .re_i    (in_accept),
      .raddr_i (rd_row),
      .rdata_o (stamp_rd[w])
    );

    clru_ram #(.Width(DataW), .Depth(DataDepth)) u_data_ram (
      .clk_i   (clk_i),
      .we_i    (data_we[w]),
      .waddr_i (data_waddr),
      .wdata_i (s1_fill_word_q),
      .re_i    (in_accept),
      .raddr_i (data_raddr),
      .rdata_o (data_rd[w])
    );

    // A stamp that was never written reads as zero.
    assign way_valid[w] = slot_valid_q[{s1_row_q, WayW'(w)}];
    assign way_match[w] = way_valid[w] && (tag_rd[w] == s1_tag_q);
    assign way_stamp[w] = stamp_set_q[{s1_row_q, WayW'(w)}] ? stamp_rd[w] : '0;
  end

  clru_pkg::way_sel_t sel;

  clru_way_sel u_way_sel (
    .valid_i (way_valid),
    .match_i (way_match),
    .stamp_i (way_stamp),
    .sel_o   (sel)
  );

  // --------------------------------------------------------------------------
  // Decide stage logic
  // --------------------------------------------------------------------------
  logic             lk_act, fl_act, lk_go, fl_go;
  logic             lk_hit, lk_cold;
  logic [WayW-1:0]  way_use;
  logic [SlotW-1:0] slot_use;
  logic             fill_we, fill_hit_off, fill_done;
  logic [3:0]       prog_next;
  logic             s1_result;
  logic             out_valid_q;
  logic [DataW-1:0] done_word;

  assign lk_act = s1_valid_q && (s1_func_q == clru_pkg::FuncLookup) && !fill_pending_q;
  assign fl_act = s1_valid_q && (s1_func_q == clru_pkg::FuncFill) && fill_pending_q;

  assign lk_hit  = assoc ? sel.hit : way_match[s1_bank_q];
  assign lk_cold = assoc ? sel.cold : !way_valid[s1_bank_q];
  assign way_use = assoc ? (sel.hit ? sel.hit_way : sel.victim_way) : s1_bank_q;
  assign slot_use = {s1_row_q, way_use};

  // Fill words past the block storage are counted but not stored. The fill
  // ends once the words received reach or pass the block length, so a block
  // length lowered during the fill ends it at the latest on the next word.
  assign fill_we      = fill_progress_q < 4'(clru_pkg::BlockWords);
  assign fill_hit_off = fill_we && (fill_progress_q[OffW-1:0] == pending_off_q);
  assign prog_next    = fill_progress_q + 4'd1;
  assign fill_done    = !((prog_next < words) && (prog_next != 4'd0));
  assign done_word    = fill_hit_off ? s1_fill_word_q : req_word_q;

  assign s1_result = lk_act || (fl_act && fill_done);
  assign s1_fire   = s1_valid_q && (!s1_result || !out_valid_q || out_o.ready);
  assign lk_go     = lk_act && s1_fire;
  assign fl_go     = fl_act && s1_fire;

  for (genvar w = 0; w < Ways; w++) begin : g_we
    assign tag_we[w]   = lk_go && !lk_hit && (way_use == WayW'(w));
    assign stamp_we[w] = lk_go && assoc && (way_use == WayW'(w));
    assign data_we[w]  = fl_go && fill_we && (pending_slot_q[WayW-1:0] == WayW'(w));
  end

  logic [CntW-1:0] ref_cnt_d, hit_cnt_d, miss_cnt_d, cold_cnt_d, hot_cnt_d;

  assign ref_cnt_d  = ref_cnt_q + CntW'(lk_go);
  assign hit_cnt_d  = hit_cnt_q + CntW'(lk_go && lk_hit);
  assign miss_cnt_d = miss_cnt_q + CntW'(lk_go && !lk_hit);
  assign cold_cnt_d = cold_cnt_q + CntW'(lk_go && !lk_hit && lk_cold);
  assign hot_cnt_d  = hot_cnt_q + CntW'(lk_go && !lk_hit && !lk_cold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cnt_q  <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      cold_cnt_q <= '0;
      hot_cnt_q  <= '0;
    end else begin
      ref_cnt_q  <= ref_cnt_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      cold_cnt_q <= cold_cnt_d;
      hot_cnt_q  <= hot_cnt_d;
    end
  end

  // A miss claims its slot at once: valid with the new tag, fill pending.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (lk_go && !lk_hit) begin
      slot_valid_q[slot_use] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_set_q <= '0;
    end else if (lk_go && assoc) begin
      stamp_set_q[slot_use] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_pending_q  <= 1'b0;
      pending_slot_q  <= '0;
      pending_off_q   <= '0;
      fill_progress_q <= '0;
    end else if (lk_go && !lk_hit) begin
      fill_pending_q  <= 1'b1;
      pending_slot_q  <= slot_use;
      pending_off_q   <= s1_off_q;
      fill_progress_q <= '0;
    end else if (fl_go) begin
      if (fill_done) begin
        fill_pending_q  <= 1'b0;
        fill_progress_q <= '0;
      end else begin
        fill_progress_q <= prog_next;
      end
    end
  end

  // The requested word of the pending block is tracked here: the victim's
  // old word at the miss, replaced when the fill writes that offset.
  always_ff @(posedge clk_i) begin
    if (lk_go && !lk_hit) begin
      req_word_q <= data_rd[way_use];
    end else if (fl_go && fill_hit_off) begin
      req_word_q <= s1_fill_word_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  clru_pkg::out_item_t res_d;
  clru_pkg::out_item_t out_q;

  always_comb begin
    res_d            = '0;
    res_d.ref_total  = ref_cnt_d;
    res_d.hit_total  = hit_cnt_d;
    res_d.miss_total = miss_cnt_d;
    res_d.cold_total = cold_cnt_d;
    res_d.hot_total  = hot_cnt_d;
    if (lk_act) begin
      if (lk_hit) begin
        res_d.kind      = clru_pkg::KindHit;
        res_d.read_word = data_rd[way_use];
      end else begin
        res_d.kind       = clru_pkg::KindFill;
        res_d.fill_base  = s1_base_q;
        res_d.fill_count = words;
        res_d.cold_miss  = lk_cold;
      end
    end else begin
      res_d.kind      = clru_pkg::KindDone;
      res_d.read_word = done_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_result) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every counted reference is exactly one hit or one miss.
  a_ref_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_cnt_q + miss_cnt_q) == ref_cnt_q)
    else $error("hit and miss counts do not add up to the reference count");

  // Every miss is exactly one cold or one hot miss.
  a_miss_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cold_cnt_q + hot_cnt_q) == miss_cnt_q)
    else $error("cold and hot counts do not add up to the miss count");

  // Fill progress only moves while a fill is pending.
  a_prog_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_pending_q |-> (fill_progress_q == 4'd0))
    else $error("fill progress nonzero with no fill pending");

  // The last fill word closes the pending fill.
  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_go && fill_done) |=> !fill_pending_q)
    else $error("fill still pending after its last word");

endmodule

### tb/tb_cache_lookup_dm_sa_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cache_lookup_dm_sa_lru: self-checking bench of the word-read lookup cache
// Drives lookup and fill-word items with random gaps, stalls the result side
// at random, and checks each result item against a cycle-free cache model.
// ----------------------------------------------------------------------------
module tb_cache_lookup_dm_sa_lru;
  import clru_pkg::*;

  localparam int unsigned MaxSlots   = 256;
  localparam int unsigned DataDepth  = MaxSlots * BlockWords;
  // Quiet cycles allowed with no item moving on any channel. The slowest
  // correct gap is the largest send gap plus the largest result stall plus the
  // passage through the pipe and the idle wait before a register write.
  localparam int unsigned QuietLimit = 2000;

  logic clk_i;
  logic rst_ni;

  clru_cfg_if cfg_ch ();
  clru_in_if  in_ch ();
  clru_out_if out_ch ();

  cache_lookup_dm_sa_lru #(
    .MaxSlots(MaxSlots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Largest idle draw of the sender and of the result receiver. Each phase
  // picks its own values, so some phases run with no idling at all.
  int unsigned gap_max   = 3;
  int unsigned stall_max = 3;
  int unsigned mismatches = 0;

  // --------------------------------------------------------------------------
  // Cache model: configuration, slot arrays, block words and counters. All
  // of it starts at its reset value; the block words carry a written flag so
  // that the stimulus never reads a word that was never filled.
  // --------------------------------------------------------------------------
  bit              mode_q       = ModeDirect;
  bit [1:0]        block_bits_q = 2'd0;
  bit [3:0]        set_bits_q   = SetBitsReset;

  bit              line_valid   [MaxSlots];
  bit [TagW-1:0]   line_tag     [MaxSlots];
  bit [StampW-1:0] line_stamp   [MaxSlots];
  bit [DataW-1:0]  line_data    [DataDepth];
  bit              line_data_ok [DataDepth];

  bit [CntW-1:0]   n_refs, n_hits, n_misses, n_cold, n_hot;

  bit              fill_busy;
  int unsigned     fill_line;
  int unsigned     fill_word_off;
  bit [3:0]        fill_done_cnt;

  // Results the model has produced and the block has not yet delivered.
  out_item_t       cache_replies_q [$];

  // The set index shrinks until sets times ways fit in the slot array.
  function automatic int unsigned set_bits_in_use();
    int unsigned k;
    k = set_bits_q;
    while (k > 0 && ((mode_q ? Ways : 1) << k) > MaxSlots) k--;
    return k;
  endfunction

  function automatic void split_addr(input bit [AddrW-1:0] a, output bit [TagW-1:0] tag,
                                     output int unsigned set_idx, output int unsigned off,
                                     output bit [AddrW-1:0] base);
    int unsigned k;
    int unsigned b;
    k = set_bits_in_use();
    b = block_bits_q;
    tag = TagW'(a >> (k + b + 2));
    set_idx = (a >> (b + 2)) & ((32'd1 << k) - 1);
    off = (a >> 2) & ((32'd1 << b) - 1);
    base = (a >> (b + 2)) << (b + 2);
  endfunction

  // Finds the slot a lookup uses: the matching way on a hit, otherwise the
  // victim. In four-way mode the victim is the last invalid way, or else the
  // way with the oldest stamp, the lowest way winning ties.
  function automatic void locate(input bit [TagW-1:0] tag, input int unsigned set_idx,
                                 output int unsigned slot, output bit hit, output bit cold);
    int unsigned first;
    int unsigned old_way;
    bit [StampW-1:0] oldest;
    int inval;
    hit = 1'b0;
    if (mode_q == ModeDirect) begin
      slot = set_idx;
      hit  = line_valid[slot] && line_tag[slot] == tag;
      cold = !line_valid[slot];
    end else begin
      first   = set_idx * Ways;
      oldest  = line_stamp[first];
      old_way = 0;
      inval   = -1;
      slot    = first;
      for (int i = 0; i < Ways; i++) begin
        if (line_valid[first + i]) begin
          if (line_tag[first + i] == tag) begin
            hit  = 1'b1;
            slot = first + i;
            break;
          end
        end else begin
          inval = i;
        end
        if (line_stamp[first + i] < oldest) begin
          oldest  = line_stamp[first + i];
          old_way = i;
        end
      end
      cold = inval >= 0;
      if (!hit) slot = first + (cold ? inval : old_way);
    end
  endfunction

  // True when a lookup of this address would hit a block word never filled.
  function automatic bit reads_unfilled(input bit [AddrW-1:0] a);
    bit [TagW-1:0] tag;
    bit [AddrW-1:0] base;
    int unsigned set_idx, off, slot;
    bit hit, cold;
    if (fill_busy) return 1'b0;
    split_addr(a, tag, set_idx, off, base);
    locate(tag, set_idx, slot, hit, cold);
    return hit && !line_data_ok[slot * BlockWords + off];
  endfunction

  // Applies one accepted item to the model and queues the result it causes.
  // Returns 0 for an item the block ignores.
  function automatic bit cache_access(input in_item_t item);
    out_item_t r;
    bit [TagW-1:0] tag;
    bit [AddrW-1:0] base;
    int unsigned words, set_idx, off, slot;
    bit hit, cold;
    words = 1 << block_bits_q;
    r = '0;
    if (item.func == FuncFill) begin
      if (!fill_busy) return 1'b0;
      if (fill_done_cnt < BlockWords) begin
        line_data[fill_line * BlockWords + fill_done_cnt]    = item.fill_word;
        line_data_ok[fill_line * BlockWords + fill_done_cnt] = 1'b1;
      end
      fill_done_cnt = fill_done_cnt + 4'd1;
      // A block length change mid-fill ends the fill at the first word that
      // reaches the current length.
      if (fill_done_cnt < words && fill_done_cnt != 0) return 1'b1;
      fill_busy     = 1'b0;
      fill_done_cnt = '0;
      r.kind        = KindDone;
      r.read_word   = line_data[fill_line * BlockWords + fill_word_off];
    end else begin
      if (fill_busy) return 1'b0;
      split_addr(item.addr, tag, set_idx, off, base);
      n_refs++;
      locate(tag, set_idx, slot, hit, cold);
      if (mode_q == ModeAssoc) line_stamp[slot] = n_refs;
      if (hit) begin
        n_hits++;
        r.kind      = KindHit;
        r.read_word = line_data[slot * BlockWords + off];
      end else begin
        n_misses++;
        if (cold) n_cold++;
        else n_hot++;
        line_valid[slot] = 1'b1;
        line_tag[slot]   = tag;
        fill_busy        = 1'b1;
        fill_line        = slot;
        fill_word_off    = off;
        fill_done_cnt    = '0;
        r.kind           = KindFill;
        r.fill_base      = base;
        r.fill_count     = 4'(words);
        r.cold_miss      = cold;
      end
    end
    r.ref_total  = n_refs;
    r.hit_total  = n_hits;
    r.miss_total = n_misses;
    r.cold_total = n_cold;
    r.hot_total  = n_hot;
    cache_replies_q.push_back(r);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%t %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    if (cache_replies_q.size() == 0) begin
      $display("%t result item with none expected: expected nothing, actual kind %0d",
               $time, got.kind);
      mismatches++;
      return;
    end
    want = cache_replies_q.pop_front();
    check_field("kind",       want.kind,       got.kind);
    check_field("read_word",  want.read_word,  got.read_word);
    check_field("fill_base",  want.fill_base,  got.fill_base);
    check_field("fill_count", want.fill_count, got.fill_count);
    check_field("cold_miss",  want.cold_miss,  got.cold_miss);
    check_field("ref_total",  want.ref_total,  got.ref_total);
    check_field("hit_total",  want.hit_total,  got.hit_total);
    check_field("miss_total", want.miss_total, got.miss_total);
    check_field("cold_total", want.cold_total, got.cold_total);
    check_field("hot_total",  want.hot_total,  got.hot_total);
  endtask

  // --------------------------------------------------------------------------
  // Clock, result receiver and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver draws a stall for every result item. Ready drops after the
  // item is taken and comes back when the stall runs out; with no stall it
  // simply stays high, so it is never lowered and raised in the same step.
  initial begin : reply_sink
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_reply(out_ch.data);
        hold = $urandom_range(stall_max, 0);
        if (hold != 0) out_ch.ready <= 1'b0;
      end else if (out_ch.ready !== 1'b1) begin
        if (hold != 0) hold--;
        if (hold == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run when no channel moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%t watchdog: no item moved for %0d cycles", $time, QuietLimit);
    $display("tb_cache_lookup_dm_sa_lru NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // Sends one item after a random gap and feeds it to the model once taken.
  // Valid is left high after acceptance so that a back-to-back item follows
  // without a bubble; whoever pauses next lowers it.
  task automatic send_item(input logic func, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] word, output bit took);
    in_item_t item;
    int unsigned gap;
    item.func      = func;
    item.addr      = addr;
    item.fill_word = word;
    gap = $urandom_range(gap_max, 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    took = cache_access(item);
  endtask

  // Waits until every expected result has arrived, then lets a dropped item
  // still in the two-stage pipe drain out.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (cache_replies_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Writes all three registers while the block is idle.
  task automatic set_config(input bit mode, input bit [1:0] blk_bits,
                            input bit [3:0] set_bits);
    cfg_wr_t writes [3];
    wait_drain();
    writes[0].index = CfgMode;
    writes[0].value = mode;
    writes[1].index = CfgBlockBits;
    writes[1].value = blk_bits;
    writes[2].index = CfgSetBits;
    writes[2].value = set_bits;
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_ch.data <= writes[i];
      do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
      case (writes[i].index)
        CfgMode:      mode_q       = writes[i].value[0];
        CfgBlockBits: block_bits_q = writes[i].value[1:0];
        CfgSetBits:   set_bits_q   = writes[i].value[3:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration: direct mapped, one word per block, four set bits.
  // A stray fill word is dropped, then a cold miss, its fill and a hit, and a
  // miss at the top of the address space.
  task automatic test_after_reset();
    bit took;
    send_item(FuncFill,   32'h0000_0000, 32'hFFFF_FFFF, took);
    send_item(FuncLookup, 32'h0000_0000, 32'h0000_0000, took);
    send_item(FuncFill,   32'h0000_0000, 32'hFFFF_FFFF, took);
    send_item(FuncLookup, 32'h0000_0000, 32'h0000_0000, took);
    send_item(FuncLookup, 32'hFFFF_FFFF, 32'h0000_0000, took);
    send_item(FuncFill,   32'hFFFF_FFFF, 32'h0000_0000, took);
  endtask

  // Eight-word blocks in a single set. A lookup during the pending fill is
  // dropped; the block length then shrinks to two words mid-fill, so the
  // next fill word ends the fill. The requested word (offset one) was loaded.
  task automatic test_fill_reconfig();
    bit took;
    set_config(ModeDirect, 2'd3, 4'd0);
    send_item(FuncLookup, 32'hFFFF_FFE4, $urandom(), took);
    repeat (3) send_item(FuncFill, $urandom(), $urandom(), took);
    send_item(FuncLookup, 32'h0000_0000, $urandom(), took);
    set_config(ModeDirect, 2'd1, 4'd0);
    send_item(FuncFill, $urandom(), $urandom(), took);
  endtask

  // Four-way mode with an oversized set index (clamped to six bits). Four
  // tags fill the set as cold misses, last invalid way first; a hit refreshes
  // the first tag's stamp, and a fifth tag evicts the oldest way as a hot miss.
  task automatic test_lru_victim();
    bit took;
    bit [AddrW-1:0] addrs [5];
    addrs = '{32'h0000_00FC, 32'h0000_01FC, 32'h0000_02FC, 32'h0000_03FC, 32'hFFFF_FFFC};
    set_config(ModeAssoc, 2'd0, 4'd15);
    for (int i = 0; i < 4; i++) begin
      send_item(FuncLookup, addrs[i], $urandom(), took);
      send_item(FuncFill, $urandom(), $urandom(), took);
    end
    send_item(FuncLookup, addrs[0], $urandom(), took);
    send_item(FuncLookup, addrs[4], $urandom(), took);
    send_item(FuncFill, $urandom(), $urandom(), took);
  endtask

  // Random traffic under several configurations, the extremes first. Most
  // lookups come from a small pool of tags and set offsets so that hits, cold
  // misses and evictions all occur; the rest are fully random addresses. A
  // miss is followed by its fill words, with an occasional dropped lookup
  // mixed in, and stray fill words show up now and then while idle.
  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    bit [15:0] tag_pool [6];
    bit [15:0] low_pool [4];
    bit [AddrW-1:0] a;
    int unsigned counted;
    bit took;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: set_config(ModeDirect, 2'd0, 4'd0);
        1: set_config(ModeAssoc,  2'd3, 4'd8);
        2: set_config(ModeDirect, 2'd3, 4'd8);
        3: set_config(ModeAssoc,  2'd0, 4'd0);
        default: set_config($urandom_range(1, 0), $urandom_range(3, 0), $urandom_range(15, 0));
      endcase
      case ($urandom_range(2, 0))
        0: gap_max = 0;
        1: gap_max = 12;
        default: gap_max = $urandom_range(12, 1);
      endcase
      case ($urandom_range(2, 0))
        0: stall_max = 0;
        1: stall_max = 12;
        default: stall_max = $urandom_range(12, 1);
      endcase
      foreach (tag_pool[i]) tag_pool[i] = $urandom();
      foreach (low_pool[i]) low_pool[i] = $urandom();

      counted = 0;
      while (counted < per_phase) begin
        if (fill_busy) begin
          if ($urandom_range(99, 0) < 8) send_item(FuncLookup, $urandom(), $urandom(), took);
          else send_item(FuncFill, $urandom(), $urandom(), took);
        end else if ($urandom_range(99, 0) < 5) begin
          send_item(FuncFill, $urandom(), $urandom(), took);
        end else begin
          if ($urandom_range(99, 0) < 65) begin
            a = {tag_pool[$urandom_range(5, 0)], low_pool[$urandom_range(3, 0)]};
            a = a ^ ($urandom_range(7, 0) << 2) ^ $urandom_range(3, 0);
          end else begin
            a = $urandom();
          end
          // After a block length change some slots hold only part of a block.
          while (reads_unfilled(a)) a = $urandom();
          send_item(FuncLookup, a, $urandom(), took);
        end
        if (took) counted++;
      end
      // Close a pending fill so the next configuration starts from a clean block.
      while (fill_busy) send_item(FuncFill, $urandom(), $urandom(), took);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    gap_max   = 12;
    stall_max = 12;
    test_fill_reconfig();
    gap_max   = 0;
    stall_max = 0;
    test_lru_victim();
    test_random_traffic(8, 100);

    wait_drain();
    if (mismatches == 0) begin
      $display("tb_cache_lookup_dm_sa_lru OK");
    end else begin
      $display("tb_cache_lookup_dm_sa_lru NOT OK");
    end
    $finish;
  end

endmodule
